/* rtl/lrs_pkg.sv */
`default_nettype none
package lrs_pkg;

	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_LEARNING_RATE = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FEATURE_COUNT = 4'd1;

	localparam logic [15:0] LEARNING_RATE_RESET = 16'd66;
	localparam logic [4:0]  FEATURE_COUNT_RESET = 5'd11;

	localparam logic [1:0] OP_CLEAR   = 2'd0;
	localparam logic [1:0] OP_TRAIN   = 2'd1;
	localparam logic [1:0] OP_PREDICT = 2'd2;
	localparam logic [1:0] OP_IGNORE  = 2'd3;

	localparam int QUEUE_DEPTH = 2;

	typedef enum logic [1:0] {
		K_CLEAR   = 2'd0,
		K_FEATURE = 2'd1,
		K_TARGET  = 2'd2
	} item_kind_t;

	typedef struct packed {
		item_kind_t         kind;
		logic               train;
		logic signed [31:0] value;
	} queue_item_t;

	typedef struct packed {
		logic [1:0] count;
	} front_status_t;

	typedef struct packed {
		logic [15:0] learning_rate;
		logic [4:0]  feature_count;
	} model_cfg_t;

	typedef struct packed {
		logic               hit;
		logic signed [31:0] val;
	} sat_val_t;

	typedef struct packed {
		logic               hit;
		logic signed [47:0] val;
	} sat_sum_t;

	// round to nearest, halves up, drop 16 fraction bits
	function automatic logic signed [47:0] rnd16(input logic signed [63:0] v);
		logic signed [63:0] t;
		t = v + 64'sd32768;
		return t[63:16];
	endfunction

	function automatic sat_sum_t sat48(input logic signed [48:0] v);
		sat_sum_t r;
		if (v > 49'sh0_7FFF_FFFF_FFFF) begin
			r.hit = 1'b1;
			r.val = 48'sh7FFF_FFFF_FFFF;
		end else if (v < -49'sh0_8000_0000_0000) begin
			r.hit = 1'b1;
			r.val = -48'sh8000_0000_0000;
		end else begin
			r.hit = 1'b0;
			r.val = v[47:0];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

/* rtl/lrs_if.sv */
`default_nettype none
interface lrs_in_if import lrs_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [1:0]         operation;
	logic signed [31:0] sample_value;
	logic               row_end;
	modport source(output valid, operation, sample_value, row_end, input ready);
	modport sink(input valid, operation, sample_value, row_end, output ready);
endinterface

interface lrs_out_if import lrs_pkg::*; ();
	logic               valid;
	logic               ready;
	logic signed [31:0] model_value;
	logic               value_kind;
	logic               saturated;
	modport source(output valid, model_value, value_kind, saturated, input ready);
	modport sink(input valid, model_value, value_kind, saturated, output ready);
endinterface

interface lrs_cfg_if import lrs_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

/* rtl/lrs_front.sv */
`default_nettype none
module lrs_front import lrs_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	lrs_in_if.sink       samples,
	output queue_item_t  q_item,
	output logic         q_valid,
	input  wire logic    q_pop,
	output front_status_t status
);

	queue_item_t slot_q [QUEUE_DEPTH];
	logic [1:0]  count_q;
	logic        wr_q;
	logic        rd_q;
	logic        push;
	logic        take;
	queue_item_t cls;

	assign samples.ready = (count_q != 2'(QUEUE_DEPTH));
	assign take = samples.valid && samples.ready;
	// ignored operations are dropped here
	assign push = take && (samples.operation != OP_IGNORE);

	always_comb begin
		cls.value = samples.sample_value;
		cls.train = (samples.operation == OP_TRAIN);
		if (samples.operation == OP_CLEAR)
			cls.kind = K_CLEAR;
		else if (samples.row_end)
			cls.kind = K_TARGET;
		else
			cls.kind = K_FEATURE;
	end

	assign q_valid = (count_q != 2'd0);
	assign q_item = slot_q[rd_q];
	assign status.count = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
			wr_q <= 1'b0;
			rd_q <= 1'b0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (q_pop && q_valid) begin
				rd_q <= ~rd_q;
			end
			unique case ({push, q_pop && q_valid})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= cls;
		end
	end

endmodule
`default_nettype wire

/* rtl/lrs_back.sv */
`default_nettype none
module lrs_back import lrs_pkg::*; #(
	parameter int MAX_FEATURES = 16,
	parameter int VALUE_WIDTH  = 32
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire model_cfg_t   cfg,
	input  wire queue_item_t  q_item,
	input  wire logic         q_valid,
	output logic              q_pop,
	lrs_out_if.source         results
);

	localparam int IW  = $clog2(MAX_FEATURES + 1);
	localparam int FW  = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
	localparam int VWE = (VALUE_WIDTH > 32) ? 32 : ((VALUE_WIDTH < 16) ? 16 : VALUE_WIDTH);
	localparam int CW  = IW + 6;
	localparam logic signed [48:0] VHI = (49'sd1 <<< (VWE - 1)) - 49'sd1;
	localparam logic signed [48:0] VLO = -VHI - 49'sd1;

	typedef enum logic [7:0] {
		S_IDLE = 8'b0000_0001,
		S_ACC  = 8'b0000_0010,
		S_ERR  = 8'b0000_0100,
		S_STEP = 8'b0000_1000,
		S_BIAS = 8'b0001_0000,
		S_WMUL = 8'b0010_0000,
		S_WUPD = 8'b0100_0000,
		S_OUT  = 8'b1000_0000
	} back_state_t;

	function automatic sat_val_t sat_v(input logic signed [48:0] v);
		sat_val_t r;
		logic signed [48:0] c;
		if (v > VHI) begin
			r.hit = 1'b1;
			c = VHI;
		end else if (v < VLO) begin
			r.hit = 1'b1;
			c = VLO;
		end else begin
			r.hit = 1'b0;
			c = v;
		end
		r.val = c[31:0];
		return r;
	endfunction

	back_state_t        state_q;
	logic signed [31:0] coef_q [MAX_FEATURES + 1];
	logic signed [31:0] fbuf_q [MAX_FEATURES];
	logic [IW-1:0]      idx_q;
	logic [IW-1:0]      wi_q;
	logic signed [47:0] sum_q;
	logic               row_sat_q;
	logic signed [63:0] prod_q;
	logic signed [31:0] yhat_q;
	logic signed [31:0] x_q;
	logic signed [31:0] err_q;
	logic signed [32:0] s_q;
	logic               train_q;
	logic               out_valid_q;
	logic signed [31:0] out_value_q;
	logic               out_kind_q;
	logic               out_sat_q;

	logic [IW-1:0]      craddr;
	logic signed [31:0] crd;
	logic               feat_ok;
	logic [CW-1:0]      idx_w;
	logic [CW-1:0]      fc_w;
	logic signed [63:0] fprod;
	logic signed [47:0] p_r;
	sat_sum_t           sum_r;
	sat_val_t           yhat_r;
	sat_val_t           err_r;
	logic signed [48:0] lr_prod;
	logic signed [47:0] s_r;
	sat_val_t           bias_r;
	logic signed [64:0] wprod;
	logic signed [47:0] d_r;
	sat_val_t           upd_r;
	logic               out_free;
	logic [IW-1:0]      wi_next;

	assign craddr = (state_q == S_WUPD) ? wi_q + IW'(1) : idx_q + IW'(1);
	assign crd = coef_q[craddr];

	assign idx_w = CW'(idx_q);
	assign fc_w = CW'(cfg.feature_count);
	assign feat_ok = (idx_w < CW'(MAX_FEATURES)) &&
		((idx_w < fc_w) || ((fc_w == '0) && (idx_w == '0)));

	assign fprod = crd * q_item.value;
	assign p_r = rnd16(prod_q);
	assign sum_r = sat48({sum_q[47], sum_q} + {p_r[47], p_r});
	assign yhat_r = sat_v({sum_q[47], sum_q} + 49'(coef_q[0]));
	assign err_r = sat_v(49'(yhat_q) - 49'(x_q));
	assign lr_prod = $signed({1'b0, cfg.learning_rate}) * err_q;
	assign s_r = rnd16(prod_q);
	assign bias_r = sat_v(49'(coef_q[0]) - {s_r[47], s_r});
	assign wprod = s_q * fbuf_q[wi_q[FW-1:0]];
	assign d_r = rnd16(prod_q);
	assign upd_r = sat_v(49'(crd) - {d_r[47], d_r});
	assign wi_next = wi_q + IW'(1);

	assign out_free = !out_valid_q || results.ready;
	assign q_pop = (state_q == S_IDLE) && q_valid;

	assign results.valid = out_valid_q;
	assign results.model_value = out_value_q;
	assign results.value_kind = out_kind_q;
	assign results.saturated = out_sat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q <= '0;
			wi_q <= '0;
			sum_q <= '0;
			row_sat_q <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i <= MAX_FEATURES; i++) begin
				coef_q[i] <= '0;
			end
		end else begin
			if ((state_q == S_OUT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						unique case (q_item.kind)
							K_CLEAR: begin
								for (int i = 0; i <= MAX_FEATURES; i++) begin
									coef_q[i] <= '0;
								end
								idx_q <= '0;
								sum_q <= '0;
								row_sat_q <= 1'b0;
							end
							K_FEATURE: begin
								if (feat_ok) begin
									state_q <= S_ACC;
								end
							end
							K_TARGET: begin
								if (yhat_r.hit) begin
									row_sat_q <= 1'b1;
								end
								state_q <= q_item.train ? S_ERR : S_OUT;
							end
							default: ;
						endcase
					end
				end
				S_ACC: begin
					sum_q <= sum_r.val;
					if (sum_r.hit) begin
						row_sat_q <= 1'b1;
					end
					idx_q <= idx_q + IW'(1);
					state_q <= S_IDLE;
				end
				S_ERR: begin
					if (err_r.hit) begin
						row_sat_q <= 1'b1;
					end
					state_q <= S_STEP;
				end
				S_STEP: begin
					state_q <= S_BIAS;
				end
				S_BIAS: begin
					coef_q[0] <= bias_r.val;
					if (bias_r.hit) begin
						row_sat_q <= 1'b1;
					end
					wi_q <= '0;
					state_q <= (idx_q == '0) ? S_OUT : S_WMUL;
				end
				S_WMUL: begin
					state_q <= S_WUPD;
				end
				S_WUPD: begin
					coef_q[craddr] <= upd_r.val;
					if (upd_r.hit) begin
						row_sat_q <= 1'b1;
					end
					wi_q <= wi_next;
					state_q <= (wi_next == idx_q) ? S_OUT : S_WMUL;
				end
				S_OUT: begin
					if (out_free) begin
						idx_q <= '0;
						sum_q <= '0;
						row_sat_q <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (q_valid && (q_item.kind == K_FEATURE) && feat_ok) begin
					fbuf_q[idx_q[FW-1:0]] <= q_item.value;
					prod_q <= fprod;
				end
				if (q_valid && (q_item.kind == K_TARGET)) begin
					yhat_q <= yhat_r.val;
					x_q <= q_item.value;
					train_q <= q_item.train;
				end
			end
			S_ERR:  err_q <= err_r.val;
			S_STEP: prod_q <= 64'(lr_prod);
			S_BIAS: s_q <= s_r[32:0];
			S_WMUL: prod_q <= wprod[63:0];
			S_OUT: begin
				if (out_free) begin
					out_value_q <= train_q ? err_q : yhat_q;
					out_kind_q <= train_q;
					out_sat_q <= row_sat_q;
				end
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire

/* rtl/linear_regression_sgd_trainer.sv */
`default_nettype none
// Linear regression trainer and predictor in signed Q16.16. Feed a row one
// element per transaction (features, then the target with row_end set); a
// target yields one result, the prediction or the training error, once the
// whole coefficient update of the row is done. A two-entry queue in front lets
// the source keep sending while the core works. The core pops an item only
// while idle: a feature is multiplied and accumulated (one beyond the feature
// count is dropped), a training target runs the error, step, bias and weight
// update states, and a target waits longer while its result is held.
module linear_regression_sgd_trainer import lrs_pkg::*; #(
	parameter int MAX_FEATURES = 16,
	parameter int VALUE_WIDTH  = 32
) (
	input  wire logic clk,
	input  wire logic arst_n,
	lrs_in_if.sink    samples,
	lrs_out_if.source results,
	lrs_cfg_if.sink   cfg
);

	model_cfg_t    cfg_q;
	queue_item_t   q_item;
	logic          q_valid;
	logic          q_pop;
	front_status_t fstat;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.learning_rate <= LEARNING_RATE_RESET;
			cfg_q.feature_count <= FEATURE_COUNT_RESET;
		end else if (cfg.valid) begin
			if (cfg.index == CFG_LEARNING_RATE)
				cfg_q.learning_rate <= cfg.data;
			else if (cfg.index == CFG_FEATURE_COUNT)
				cfg_q.feature_count <= cfg.data[4:0];
		end
	end

	lrs_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.samples(samples),
		.q_item (q_item),
		.q_valid(q_valid),
		.q_pop  (q_pop),
		.status (fstat)
	);

	lrs_back #(
		.MAX_FEATURES(MAX_FEATURES),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.q_item (q_item),
		.q_valid(q_valid),
		.q_pop  (q_pop),
		.results(results)
	);

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fstat.count <= 2'(QUEUE_DEPTH))
		else $error("queue count overflow");

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!samples.ready |-> fstat.count == 2'(QUEUE_DEPTH))
		else $error("input stalled with queue space");

	a_push_held: assert property (@(posedge clk) disable iff (!arst_n)
		samples.valid && samples.ready && samples.operation != OP_IGNORE
		|=> fstat.count != 2'd0)
		else $error("queued transaction lost");

endmodule
`default_nettype wire
